// ===== rtl/fct_pkg.sv =====
// Shared types and constants for the frustum cull tester.
// No dependencies; fct_plane_lane and frustum_cull_tester_unit import this package.
package fct_pkg;

  localparam int PLANE_COUNT = 6;
  // 67 bits hold three full 64-bit products plus the aligned offset and radius
  localparam int ACC_W = 67;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_POINT  = 2'd1,
    OP_SPHERE = 2'd2,
    OP_BOX    = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar;
  } test_item_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] d;
  } plane_t;

endpackage

// ===== rtl/fct_if.sv =====
// Valid/ready channel interfaces for the frustum cull tester.
// No dependencies.
interface fct_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [2:0]  plane_index;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar;

  modport source (output valid, operation, plane_index, a_x, a_y, a_z, b_x, b_y, b_z,
                  scalar, input ready);
  modport sink (input valid, operation, plane_index, a_x, a_y, a_z, b_x, b_y, b_z,
                scalar, output ready);
endinterface

interface fct_out_if;
  logic valid;
  logic ready;
  logic passes;

  modport source (output valid, passes, input ready);
  modport sink (input valid, passes, output ready);
endinterface

// ===== rtl/fct_plane_lane.sv =====
// One plane's signed-distance test, three register stages.
// Depends on fct_pkg.
module fct_plane_lane import fct_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       en,
  input  test_item_t item,
  input  plane_t     plane,
  output logic       ok
);

  localparam int ALN_W = 32 + FRAC_BITS;

  logic signed [31:0]    px, py, pz;
  logic signed [63:0]    prod_x, prod_y, prod_z;
  logic signed [ALN_W-1:0] d_al, extra;
  logic signed [ALN_W:0] dsum;
  logic signed [ACC_W-1:0] total;

  logic signed [63:0]    prod_x_r, prod_y_r, prod_z_r;
  logic signed [ALN_W:0] dsum_r;
  logic signed [ACC_W-1:0] sum_xy_r, sum_zd_r;
  logic                  ok_r;

  // box: positive vertex per axis, max where the normal component is non-negative
  always_comb begin
    px = item.a_x;
    py = item.a_y;
    pz = item.a_z;
    if (item.op == OP_BOX) begin
      if (!plane.nx[31]) px = item.b_x;
      if (!plane.ny[31]) py = item.b_y;
      if (!plane.nz[31]) pz = item.b_z;
    end
  end

  assign prod_x = 64'(plane.nx) * 64'(px);
  assign prod_y = 64'(plane.ny) * 64'(py);
  assign prod_z = 64'(plane.nz) * 64'(pz);

  assign d_al  = $signed({plane.d, {FRAC_BITS{1'b0}}});
  assign extra = (item.op == OP_SPHERE) ? $signed({item.scalar, {FRAC_BITS{1'b0}}})
                                        : '0;
  assign dsum  = (ALN_W+1)'(d_al) + (ALN_W+1)'(extra);
  assign total = sum_xy_r + sum_zd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x_r <= prod_x;
      prod_y_r <= prod_y;
      prod_z_r <= prod_z;
      dsum_r   <= dsum;
      sum_xy_r <= ACC_W'(prod_x_r) + ACC_W'(prod_y_r);
      sum_zd_r <= ACC_W'(prod_z_r) + ACC_W'(dsum_r);
      ok_r     <= !total[ACC_W-1];
    end
  end

  assign ok = ok_r;

endmodule

// ===== rtl/frustum_cull_tester_unit.sv =====
// Frustum cull tester: six-plane table with a pipelined point/sphere/box test.
// Depends on fct_pkg, fct_if and fct_plane_lane.
//
// Usage: in_req carries one request per valid/ready handshake. A load
// (operation 0) writes plane plane_index from a_x/a_y/a_z (normal) and scalar
// (offset); indexes 6 and 7 are dropped. Loads give no result. A point,
// sphere or box test gives one passes flag on out_rsp, in request order.
// A test may follow a load in the very next cycle and sees the new plane.
// Throughput: one request per cycle unless the receiver stalls; the six
// plane lanes each run three 32x32 multiplies in parallel, then a two-level
// adder tree. A test moves through item_r, the lane registers and passes_r.
// Reset clears only the pipeline valid bits; the plane table is undefined
// until loaded, and a test must not read a plane that was never loaded.
// When the receiver stalls, the whole pipeline holds and in_req.ready drops
// until the waiting result is taken; nothing is lost or repeated.
module frustum_cull_tester_unit import fct_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  fct_in_if.sink   in_req,
  fct_out_if.source out_rsp
);

  plane_t     planes_r [PLANE_COUNT];
  test_item_t item_r, item_nxt;
  logic       v1_r, v2_r, v3_r, v4_r, out_valid_r, passes_r;
  logic       en, in_acc;
  logic [PLANE_COUNT-1:0] ok;

  assign en      = !out_valid_r || out_rsp.ready;
  assign in_acc  = in_req.valid && en;
  assign in_req.ready  = en;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.passes = passes_r;

  always_comb begin
    item_nxt.op     = op_t'(in_req.operation);
    item_nxt.a_x    = in_req.a_x;
    item_nxt.a_y    = in_req.a_y;
    item_nxt.a_z    = in_req.a_z;
    item_nxt.b_x    = in_req.b_x;
    item_nxt.b_y    = in_req.b_y;
    item_nxt.b_z    = in_req.b_z;
    item_nxt.scalar = in_req.scalar;
  end

  // lanes read the table from item_r, a register after the input, so a load in the
  // same edge as a later stage move does not disturb earlier tests
  always_ff @(posedge clk) begin
    if (in_acc && item_nxt.op == OP_LOAD && in_req.plane_index < 3'(PLANE_COUNT)) begin
      planes_r[in_req.plane_index] <= '{nx: in_req.a_x, ny: in_req.a_y,
                                        nz: in_req.a_z, d: in_req.scalar};
    end
    if (en) begin
      item_r   <= item_nxt;
      passes_r <= &ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_acc && item_nxt.op != OP_LOAD;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
    fct_plane_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .item  (item_r),
      .plane (planes_r[i]),
      .ok    (ok[i])
    );
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_req.ready)
    else $error("input stalled with empty output stage");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready && in_req.operation == OP_LOAD) |=> !v1_r)
    else $error("load request entered the result pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({v1_r, v2_r, v3_r, v4_r}))
    else $error("pipeline moved during output stall");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v4_r) |=> out_valid_r)
    else $error("result dropped on its way to the output stage");

endmodule
